/* src/hcv_pkg.sv */
// Shared types, constants and field widths for the HSV color vote classifier.
`default_nettype none

package hcv_pkg;

   localparam int PIX_W        = 8;
   localparam int CFG_COUNT_W  = 20;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 20;
   localparam int COUNT_WIDTH  = 20;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 32;
   localparam int CLASS_W      = 3;

   localparam int SAT_SCALE    = 1044480;
   localparam int HUE_SCALE    = 122880;
   localparam int SD_W         = 20;
   localparam int HD_W         = 17;
   localparam int FRAC_W       = 12;
   localparam int NUM_W        = 12;
   localparam int SPROD_W      = PIX_W + SD_W;
   localparam int HPROD_W      = NUM_W + HD_W + 1;
   localparam int ROUND_HALF   = 2048;
   localparam int HUE_WRAP     = 180;

   localparam int RED_LOW_MAX  = 10;
   localparam int RED_HIGH_MIN = 156;
   localparam int RED_HIGH_MAX = 180;
   localparam int YEL_MIN      = 26;
   localparam int YEL_MAX      = 34;
   localparam int GRN_MIN      = 35;
   localparam int GRN_MAX      = 77;
   localparam int BLU_MIN      = 100;
   localparam int BLU_MAX      = 124;

   localparam int SAT_MIN_RST   = 43;
   localparam int VAL_MIN_RST   = 46;
   localparam int MIN_COUNT_RST = 50;

   localparam int QUEUE_DEPTH  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAT_MIN   = 2'd0,
      CSR_VAL_MIN   = 2'd1,
      CSR_MIN_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_NONE   = 3'd0,
      CLS_RED    = 3'd1,
      CLS_GREEN  = 3'd2,
      CLS_BLUE   = 3'd3,
      CLS_YELLOW = 3'd4
   } color_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      color_type        cls;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

`default_nettype wire

/* src/hsv_color_vote_classifier.sv */
// Top level of the HSV color vote classifier: ports, control registers, checks.
//
// Pixels enter on the req_ stream, one BGR pixel per beat, tlast on a frame's
// last pixel. Each pixel leaves on the rsp_ stream as one beat: the pixel if it
// falls in a red, green, blue or yellow hue band with enough saturation and
// value, else white, with its class in tuser. The beat with tlast set also
// carries the frame's dominant color; the class counters clear after it.
// Thresholds are written on the csr_ channel, which is always ready; write it
// only while no pixel is in flight.
// An accepted input beat reaches its result beat through the four-stage
// conversion pipeline (min/max, reciprocal lookup, multiply, round and
// classify), the queue write and the result register.
// Throughput is one pixel per cycle. When rsp_tready is low the result
// register holds, the back end stops popping, the 4-entry queue fills, and
// then the front pipeline freezes and req_tready drops.
// Reset clears all pipeline valids, the queue, the counters and the result
// valid, and loads the thresholds with 43, 46 and 50.
`default_nettype none

module hsv_color_vote_classifier #(
   parameter int COUNT_WIDTH = hcv_pkg::COUNT_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [hcv_pkg::REQ_DATA_W-1:0]  req_tdata,  // blue_in, green_in, red_in
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // blue_out, green_out, red_out, dominant_color, zero fill
   output logic [hcv_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [hcv_pkg::CLASS_W-1:0]          rsp_tuser,  // pixel_class
   output logic                                 rsp_tlast,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hcv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hcv_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int PW = hcv_pkg::PIX_W;

   logic [PW-1:0]                   sat_min_ff, val_min_ff;
   logic [hcv_pkg::CFG_COUNT_W-1:0] min_count_ff;

   hcv_pkg::push_type  push;
   hcv_pkg::head_type  head;
   logic               queue_full;
   logic               pop;
   logic [PW-1:0]      blue_out, green_out, red_out;
   hcv_pkg::color_type pixel_class, dominant_color;
   logic               frame_done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_min_ff   <= PW'(hcv_pkg::SAT_MIN_RST);
         val_min_ff   <= PW'(hcv_pkg::VAL_MIN_RST);
         min_count_ff <= hcv_pkg::CFG_COUNT_W'(hcv_pkg::MIN_COUNT_RST);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hcv_pkg::CSR_SAT_MIN:   sat_min_ff   <= csr_data[PW-1:0];
            hcv_pkg::CSR_VAL_MIN:   val_min_ff   <= csr_data[PW-1:0];
            hcv_pkg::CSR_MIN_COUNT: min_count_ff <= csr_data[hcv_pkg::CFG_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   hcv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .blue_in    (req_tdata[PW-1:0]),
      .green_in   (req_tdata[2*PW-1:PW]),
      .red_in     (req_tdata[3*PW-1:2*PW]),
      .frame_end  (req_tlast),
      .sat_min    (sat_min_ff),
      .val_min    (val_min_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   hcv_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   hcv_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .min_count      (min_count_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .blue_out       (blue_out),
      .green_out      (green_out),
      .red_out        (red_out),
      .pixel_class    (pixel_class),
      .frame_done     (frame_done),
      .dominant_color (dominant_color)
   );

   assign rsp_tdata = {{(hcv_pkg::RSP_DATA_W - 3*PW - hcv_pkg::CLASS_W){1'b0}},
                       dominant_color, red_out, green_out, blue_out};
   assign rsp_tuser = pixel_class;
   assign rsp_tlast = frame_done;

   a_dom_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> dominant_color == hcv_pkg::CLS_NONE)
      else $error("dominant color set on a beat that does not end a frame");

   a_white_when_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && pixel_class == hcv_pkg::CLS_NONE |->
         blue_out == '1 && green_out == '1 && red_out == '1)
      else $error("unclassed pixel not masked to white");

   a_csr_sat_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == hcv_pkg::CSR_SAT_MIN |=>
         sat_min_ff == $past(csr_data[PW-1:0]))
      else $error("saturation threshold write lost");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full && !pop |-> !push.valid)
      else $error("push into a full queue");

endmodule

`default_nettype wire

/* src/hcv_front.sv */
// Front pipeline: BGR to HSV conversion and per-pixel color classification.
`default_nettype none

module hcv_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [hcv_pkg::PIX_W-1:0] blue_in,
   input  wire logic [hcv_pkg::PIX_W-1:0] green_in,
   input  wire logic [hcv_pkg::PIX_W-1:0] red_in,
   input  wire logic                      frame_end,
   input  wire logic [hcv_pkg::PIX_W-1:0] sat_min,
   input  wire logic [hcv_pkg::PIX_W-1:0] val_min,
   input  wire logic                      queue_full,
   output hcv_pkg::push_type              push
);

   localparam int ROM_DEPTH = 2 ** hcv_pkg::PIX_W;
   localparam int PW        = hcv_pkg::PIX_W;
   localparam int SSUM_W    = hcv_pkg::SPROD_W + 1;
   localparam int SVAL_W    = SSUM_W - hcv_pkg::FRAC_W;
   localparam int HSUM_W    = hcv_pkg::HPROD_W + 1;

   logic [hcv_pkg::SD_W-1:0] sd_rom [ROM_DEPTH];
   logic [hcv_pkg::HD_W-1:0] hd_rom [ROM_DEPTH];

   assign sd_rom[0] = '0;
   assign hd_rom[0] = '0;

   for (genvar gi = 1; gi < ROM_DEPTH; gi++) begin : g_rom
      localparam int SD_Q = hcv_pkg::SAT_SCALE / gi;
      localparam int SD_R = hcv_pkg::SAT_SCALE % gi;
      localparam int SD_V = SD_Q + (((2 * SD_R > gi) ||
                            ((2 * SD_R == gi) && (SD_Q % 2 == 1))) ? 1 : 0);
      localparam int HD_Q = hcv_pkg::HUE_SCALE / gi;
      localparam int HD_R = hcv_pkg::HUE_SCALE % gi;
      localparam int HD_V = HD_Q + (((2 * HD_R > gi) ||
                            ((2 * HD_R == gi) && (HD_Q % 2 == 1))) ? 1 : 0);
      assign sd_rom[gi] = hcv_pkg::SD_W'(SD_V);
      assign hd_rom[gi] = hcv_pkg::HD_W'(HD_V);
   end

   logic advance;

   // stage 1: max, min, hue numerator
   logic                                 s1_valid_ff, s1_valid_in;
   logic [PW-1:0]                        s1_v_ff, s1_v_in;
   logic [PW-1:0]                        s1_diff_ff, s1_diff_in;
   logic signed [hcv_pkg::NUM_W-1:0]     s1_num_ff, s1_num_in;
   hcv_pkg::entry_type                   s1_pix_ff, s1_pix_in;

   // stage 2: reciprocal lookups
   logic                                 s2_valid_ff;
   logic [PW-1:0]                        s2_v_ff;
   logic [PW-1:0]                        s2_diff_ff;
   logic signed [hcv_pkg::NUM_W-1:0]     s2_num_ff;
   logic [hcv_pkg::SD_W-1:0]             s2_sd_ff;
   logic [hcv_pkg::HD_W-1:0]             s2_hd_ff;
   hcv_pkg::entry_type                   s2_pix_ff;

   // stage 3: products
   logic                                 s3_valid_ff;
   logic [PW-1:0]                        s3_v_ff;
   logic [hcv_pkg::SPROD_W-1:0]          s3_sprod_ff, s3_sprod_in;
   logic signed [hcv_pkg::HPROD_W-1:0]   s3_hprod_ff, s3_hprod_in;
   hcv_pkg::entry_type                   s3_pix_ff;

   // stage 4: classified pixel
   logic                                 s4_valid_ff;
   hcv_pkg::entry_type                   s4_pix_ff, s4_pix_in;

   logic [PW-1:0]                        mx, mn;
   logic [SSUM_W-1:0]                    s_sum;
   logic [SVAL_W-1:0]                    s_val;
   logic signed [HSUM_W-1:0]             h_sum;
   logic signed [HSUM_W-1:0]             h_q;
   logic [PW-1:0]                        hue;
   logic                                 colored;

   assign advance   = !(s4_valid_ff && queue_full);
   assign req_ready = advance;
   assign s1_valid_in = req_valid;

   always_comb begin
      mx = red_in;
      mn = red_in;
      if (green_in > mx) mx = green_in;
      if (blue_in > mx)  mx = blue_in;
      if (green_in < mn) mn = green_in;
      if (blue_in < mn)  mn = blue_in;
      s1_v_in    = mx;
      s1_diff_in = mx - mn;
      if (mx == red_in) begin
         s1_num_in = $signed({4'd0, green_in}) - $signed({4'd0, blue_in});
      end else if (mx == green_in) begin
         s1_num_in = $signed({4'd0, blue_in}) - $signed({4'd0, red_in})
                   + $signed({3'd0, s1_diff_in, 1'b0});
      end else begin
         s1_num_in = $signed({4'd0, red_in}) - $signed({4'd0, green_in})
                   + $signed({2'd0, s1_diff_in, 2'b00});
      end
      s1_pix_in.blue  = blue_in;
      s1_pix_in.green = green_in;
      s1_pix_in.red   = red_in;
      s1_pix_in.cls   = hcv_pkg::CLS_NONE;
      s1_pix_in.last  = frame_end;
   end

   assign s3_sprod_in = hcv_pkg::SPROD_W'(s2_diff_ff) * hcv_pkg::SPROD_W'(s2_sd_ff);
   assign s3_hprod_in = hcv_pkg::HPROD_W'(s2_num_ff)
                      * hcv_pkg::HPROD_W'($signed({1'b0, s2_hd_ff}));

   always_comb begin
      s_sum = {1'b0, s3_sprod_ff} + SSUM_W'(hcv_pkg::ROUND_HALF);
      s_val = s_sum[SSUM_W-1:hcv_pkg::FRAC_W];
      h_sum = {s3_hprod_ff[hcv_pkg::HPROD_W-1], s3_hprod_ff}
            + HSUM_W'(hcv_pkg::ROUND_HALF);
      h_q   = h_sum >>> hcv_pkg::FRAC_W;
      hue   = h_q[PW-1:0] + (h_q[HSUM_W-1] ? PW'(hcv_pkg::HUE_WRAP) : '0);
      colored = (s_val >= SVAL_W'(sat_min)) && (s3_v_ff >= val_min);
      s4_pix_in = s3_pix_ff;
      if (colored) begin
         if (hue <= PW'(hcv_pkg::RED_LOW_MAX) ||
             (hue >= PW'(hcv_pkg::RED_HIGH_MIN) && hue <= PW'(hcv_pkg::RED_HIGH_MAX))) begin
            s4_pix_in.cls = hcv_pkg::CLS_RED;
         end else if (hue >= PW'(hcv_pkg::GRN_MIN) && hue <= PW'(hcv_pkg::GRN_MAX)) begin
            s4_pix_in.cls = hcv_pkg::CLS_GREEN;
         end else if (hue >= PW'(hcv_pkg::BLU_MIN) && hue <= PW'(hcv_pkg::BLU_MAX)) begin
            s4_pix_in.cls = hcv_pkg::CLS_BLUE;
         end else if (hue >= PW'(hcv_pkg::YEL_MIN) && hue <= PW'(hcv_pkg::YEL_MAX)) begin
            s4_pix_in.cls = hcv_pkg::CLS_YELLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_v_ff     <= s1_v_in;
         s1_diff_ff  <= s1_diff_in;
         s1_num_ff   <= s1_num_in;
         s1_pix_ff   <= s1_pix_in;
         s2_v_ff     <= s1_v_ff;
         s2_diff_ff  <= s1_diff_ff;
         s2_num_ff   <= s1_num_ff;
         s2_sd_ff    <= sd_rom[s1_v_ff];
         s2_hd_ff    <= hd_rom[s1_diff_ff];
         s2_pix_ff   <= s1_pix_ff;
         s3_v_ff     <= s2_v_ff;
         s3_sprod_ff <= s3_sprod_in;
         s3_hprod_ff <= s3_hprod_in;
         s3_pix_ff   <= s2_pix_ff;
         s4_pix_ff   <= s4_pix_in;
      end
   end

   assign push.valid = s4_valid_ff && !queue_full;
   assign push.entry = s4_pix_ff;

endmodule

`default_nettype wire

/* src/hcv_queue.sv */
// Short FIFO between the classifying front and the counting back end.
`default_nettype none

module hcv_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hcv_pkg::push_type push,
   output logic                   full,
   input  wire logic              pop,
   output hcv_pkg::head_type      head
);

   localparam int DEPTH = hcv_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   hcv_pkg::entry_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = mem[rd_ptr_ff];

endmodule

`default_nettype wire

/* src/hcv_back.sv */
// Back end: class counters, frame vote and the registered result beat.
`default_nettype none

module hcv_back #(
   parameter int COUNT_WIDTH = hcv_pkg::COUNT_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire hcv_pkg::head_type               head,
   output logic                                 pop,
   input  wire logic [hcv_pkg::CFG_COUNT_W-1:0] min_count,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [hcv_pkg::PIX_W-1:0]            blue_out,
   output logic [hcv_pkg::PIX_W-1:0]            green_out,
   output logic [hcv_pkg::PIX_W-1:0]            red_out,
   output hcv_pkg::color_type                   pixel_class,
   output logic                                 frame_done,
   output hcv_pkg::color_type                   dominant_color
);

   localparam int NCLS  = 4;
   localparam int CMP_W = (COUNT_WIDTH > hcv_pkg::CFG_COUNT_W) ?
                          COUNT_WIDTH : hcv_pkg::CFG_COUNT_W;
   localparam int PW    = hcv_pkg::PIX_W;

   logic [COUNT_WIDTH-1:0] count_ff [NCLS];
   logic [COUNT_WIDTH-1:0] count_in [NCLS];
   logic [CMP_W-1:0]       nc [NCLS];
   logic [CMP_W-1:0]       limit;
   logic                   is_max [NCLS];
   logic                   all_low;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]          blue_ff, blue_in;
   logic [PW-1:0]          green_ff, green_in;
   logic [PW-1:0]          red_ff, red_in;
   hcv_pkg::color_type     cls_ff, cls_in;
   logic                   done_ff, done_in;
   hcv_pkg::color_type     dom_ff, dom_in;

   assign pop   = head.valid && (!rsp_valid_ff || rsp_ready);
   assign limit = CMP_W'(min_count);

   always_comb begin
      for (int i = 0; i < NCLS; i++) begin
         nc[i] = CMP_W'(count_ff[i]);
         if ((head.entry.cls == hcv_pkg::color_type'(i + 1)) &&
             (count_ff[i] != {COUNT_WIDTH{1'b1}})) begin
            nc[i] = CMP_W'(count_ff[i] + 1'b1);
         end
      end
      for (int i = 0; i < NCLS; i++) begin
         is_max[i] = 1'b1;
         for (int j = 0; j < NCLS; j++) begin
            if (nc[j] > nc[i]) is_max[i] = 1'b0;
         end
      end
      all_low = 1'b1;
      for (int i = 0; i < NCLS; i++) begin
         if (nc[i] > limit) all_low = 1'b0;
      end
      for (int i = 0; i < NCLS; i++) begin
         count_in[i] = head.entry.last ? '0 : nc[i][COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      dom_in = hcv_pkg::CLS_NONE;
      if (is_max[0]) dom_in = hcv_pkg::CLS_RED;
      if (is_max[1]) dom_in = hcv_pkg::CLS_GREEN;
      if (is_max[2]) dom_in = hcv_pkg::CLS_BLUE;
      if (is_max[3]) dom_in = hcv_pkg::CLS_YELLOW;
      if (all_low || !head.entry.last) dom_in = hcv_pkg::CLS_NONE;
      if (head.entry.cls == hcv_pkg::CLS_NONE) begin
         blue_in  = '1;
         green_in = '1;
         red_in   = '1;
      end else begin
         blue_in  = head.entry.blue;
         green_in = head.entry.green;
         red_in   = head.entry.red;
      end
      cls_in  = head.entry.cls;
      done_in = head.entry.last;
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NCLS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            for (int i = 0; i < NCLS; i++) begin
               count_ff[i] <= count_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
         red_ff   <= red_in;
         cls_ff   <= cls_in;
         done_ff  <= done_in;
         dom_ff   <= dom_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign blue_out       = blue_ff;
   assign green_out      = green_ff;
   assign red_out        = red_ff;
   assign pixel_class    = cls_ff;
   assign frame_done     = done_ff;
   assign dominant_color = dom_ff;

endmodule

`default_nettype wire

/* verif/tb_hsv_color_vote_classifier.sv */
// Self-checking testbench for the HSV color vote classifier: masked pixels, classes, frame vote.
`timescale 1ns / 100ps

module tb_hsv_color_vote_classifier;
   import hcv_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int LIMIT_NS     = 2_000_000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 200;
   localparam int COUNT_MAX    = (1 << COUNT_WIDTH) - 1;
   localparam int PHASE_ITEMS  = 210;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      color_type        cls;
      logic             last;
      color_type        dom;
   } masked_pixel_t;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // blue_in, green_in, red_in
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // blue_out, green_out, red_out, dominant_color
   logic [CLASS_W-1:0]     rsp_tuser;         // pixel_class
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   masked_pixel_t expected_pixels[$];
   masked_pixel_t head;
   int unsigned   color_count[5];
   int unsigned   sat_min   = SAT_MIN_RST;
   int unsigned   val_min   = VAL_MIN_RST;
   int unsigned   min_count = MIN_COUNT_RST;
   int            fail_count = 0;
   int            idle_pct   = 0;
   int            stall_pct  = 0;
   int            hold_seq   = 0;
   int            hold_seen  = 0;
   int            hold_left  = 0;

   hsv_color_vote_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #LIMIT_NS;
      $display("Some tests failed");
      $finish;
   end

   function automatic longint div_round_even(input longint num, input longint den);
      longint q;
      longint r;
      q = num / den;
      r = num % den;
      if (2 * r > den || (2 * r == den && q[0]))
         q++;
      return q;
   endfunction

   function automatic masked_pixel_t predict_pixel(input logic [PIX_W-1:0] b, g, r,
                                                   input logic last);
      longint        bi, gi, ri, v, mn, diff, num, s, h, sd, hd;
      longint        rc, gc, bc, yc;
      masked_pixel_t res;
      color_type     cls;
      color_type     dom;
      bi = b;
      gi = g;
      ri = r;
      v  = ri;
      mn = ri;
      if (gi > v) v = gi;
      if (bi > v) v = bi;
      if (gi < mn) mn = gi;
      if (bi < mn) mn = bi;
      diff = v - mn;
      sd = (v != 0) ? div_round_even(SAT_SCALE, v) : 0;
      s  = (diff * sd + ROUND_HALF) >>> FRAC_W;
      if (v == ri)
         num = gi - bi;
      else if (v == gi)
         num = bi - ri + 2 * diff;
      else
         num = ri - gi + 4 * diff;
      hd = (diff != 0) ? div_round_even(HUE_SCALE, diff) : 0;
      h  = (num * hd + ROUND_HALF) >>> FRAC_W;
      if (h < 0)
         h += HUE_WRAP;

      cls = CLS_NONE;
      if (s >= sat_min && v >= val_min) begin
         if (h <= RED_LOW_MAX || (h >= RED_HIGH_MIN && h <= RED_HIGH_MAX))
            cls = CLS_RED;
         else if (h >= GRN_MIN && h <= GRN_MAX)
            cls = CLS_GREEN;
         else if (h >= BLU_MIN && h <= BLU_MAX)
            cls = CLS_BLUE;
         else if (h >= YEL_MIN && h <= YEL_MAX)
            cls = CLS_YELLOW;
      end
      if (cls != CLS_NONE && color_count[int'(cls)] < COUNT_MAX)
         color_count[int'(cls)]++;

      dom = CLS_NONE;
      if (last) begin
         rc = color_count[int'(CLS_RED)];
         gc = color_count[int'(CLS_GREEN)];
         bc = color_count[int'(CLS_BLUE)];
         yc = color_count[int'(CLS_YELLOW)];
         if (rc >= bc && rc >= gc && rc >= yc) dom = CLS_RED;
         if (gc >= rc && gc >= bc && gc >= yc) dom = CLS_GREEN;
         if (bc >= rc && bc >= gc && bc >= yc) dom = CLS_BLUE;
         if (yc >= bc && yc >= gc && yc >= rc) dom = CLS_YELLOW;
         if (rc <= min_count && gc <= min_count && bc <= min_count && yc <= min_count)
            dom = CLS_NONE;
         foreach (color_count[i])
            color_count[i] = 0;
      end

      res.blue  = (cls != CLS_NONE) ? b : 8'hFF;
      res.green = (cls != CLS_NONE) ? g : 8'hFF;
      res.red   = (cls != CLS_NONE) ? r : 8'hFF;
      res.cls   = cls;
      res.last  = last;
      res.dom   = dom;
      return res;
   endfunction

   // pix packs red, green, blue from the top down
   function automatic logic [REQ_DATA_W-1:0] random_pixel();
      int kind;
      int hi;
      int mid;
      int lo;
      kind = $urandom_range(0, 9);
      if (kind < 2)
         return $urandom();
      if (kind == 2) begin
         hi = $urandom_range(0, 255);
         return {hi[7:0], hi[7:0], hi[7:0]};
      end
      hi  = $urandom_range(30, 255);
      lo  = $urandom_range(0, hi / 2);
      mid = $urandom_range(lo, hi);
      case ($urandom_range(0, 5))
         0: return {hi[7:0],  mid[7:0], lo[7:0]};
         1: return {hi[7:0],  lo[7:0],  mid[7:0]};
         2: return {mid[7:0], hi[7:0],  lo[7:0]};
         3: return {lo[7:0],  hi[7:0],  mid[7:0]};
         4: return {mid[7:0], lo[7:0],  hi[7:0]};
         default: return {lo[7:0], mid[7:0], hi[7:0]};
      endcase
   endfunction

   task automatic send_beat(input logic [REQ_DATA_W-1:0] pix, input logic last);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(predict_pixel(pix[7:0], pix[15:8], pix[23:16], last));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SAT_MIN:   sat_min   = data[7:0];
         CSR_VAL_MIN:   val_min   = data[7:0];
         CSR_MIN_COUNT: min_count = data;
         default: ;
      endcase
   endtask

   task automatic random_thresholds();
      int sel;
      logic [CSR_DATA_W-1:0] data;
      data = $urandom();
      data[7:0] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 120);
      write_csr(CSR_SAT_MIN, data);
      data = $urandom();
      data[7:0] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 120);
      write_csr(CSR_VAL_MIN, data);
      sel = $urandom_range(0, 9);
      if (sel < 7)
         data = $urandom_range(0, 10);
      else if (sel < 9)
         data = $urandom_range(0, 100);
      else
         data = $urandom();
      write_csr(CSR_MIN_COUNT, data);
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_UNUSED, $urandom());
   endtask

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen  <= hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("result beat with no pixel pending");
            fail_count++;
         end else begin
            head = expected_pixels.pop_front();
            check_field("blue_out",       head.blue,  rsp_tdata[0 +: PIX_W]);
            check_field("green_out",      head.green, rsp_tdata[PIX_W +: PIX_W]);
            check_field("red_out",        head.red,   rsp_tdata[2*PIX_W +: PIX_W]);
            check_field("dominant_color", head.dom,   rsp_tdata[3*PIX_W +: CLASS_W]);
            check_field("pixel_class",    head.cls,   rsp_tuser);
            check_field("frame_done",     head.last,  rsp_tlast);
         end
      end
   end

   task automatic test_default_thresholds();
      send_beat({8'd0,   8'd0,   8'd0},   1'b0);
      send_beat({8'd255, 8'd255, 8'd255}, 1'b0);
      send_beat({8'd128, 8'd128, 8'd128}, 1'b0);
      send_beat({8'd255, 8'd0,   8'd0},   1'b0);
      send_beat({8'd0,   8'd255, 8'd0},   1'b0);
      send_beat({8'd0,   8'd0,   8'd255}, 1'b0);
      send_beat({8'd255, 8'd255, 8'd0},   1'b0);
      send_beat({8'd255, 8'd0,   8'd255}, 1'b0);
      send_beat({8'd0,   8'd255, 8'd255}, 1'b0);
      send_beat({8'd45,  8'd0,   8'd0},   1'b0);
      send_beat({8'd46,  8'd0,   8'd0},   1'b0);
      send_beat({8'd255, 8'd255, 8'd255}, 1'b1);
   endtask

   task automatic test_dominant_ties();
      write_csr(CSR_MIN_COUNT, '0);
      send_beat({8'd255, 8'd0,   8'd0},   1'b0);
      send_beat({8'd0,   8'd255, 8'd0},   1'b1);
      send_beat({8'd0,   8'd0,   8'd255}, 1'b0);
      send_beat({8'd255, 8'd255, 8'd0},   1'b1);
      send_beat({8'd255, 8'd0,   8'd0},   1'b0);
      send_beat({8'd0,   8'd255, 8'd0},   1'b0);
      send_beat({8'd0,   8'd0,   8'd255}, 1'b0);
      send_beat({8'd255, 8'd255, 8'd0},   1'b1);
      send_beat({8'd200, 8'd10,  8'd10},  1'b1);
      send_beat({8'd255, 8'd255, 8'd255}, 1'b1);
   endtask

   task automatic test_threshold_extremes();
      write_csr(CSR_SAT_MIN, '0);
      write_csr(CSR_VAL_MIN, '0);
      send_beat({8'd0, 8'd0, 8'd0}, 1'b1);
      write_csr(CSR_SAT_MIN, 20'hFFFFF);
      write_csr(CSR_VAL_MIN, 20'h000FF);
      write_csr(CSR_MIN_COUNT, 20'hFFFFF);
      send_beat({8'd0, 8'd0, 8'd255}, 1'b0);
      send_beat({8'd0, 8'd0, 8'd254}, 1'b1);
      write_csr(CSR_UNUSED, $urandom());
      write_csr(CSR_SAT_MIN, {12'hFFF, 8'd43});
      write_csr(CSR_VAL_MIN, {12'hABC, 8'd46});
      write_csr(CSR_MIN_COUNT, 20'd50);
      send_beat({8'd46, 8'd0, 8'd0}, 1'b1);
   endtask

   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct <= 0;
      hold_seq <= hold_seq + 1;
      repeat (40)
         send_beat(random_pixel(), $urandom_range(0, 9) == 0);
      drain();
   endtask

   task automatic test_random_traffic(input int idle, input int stall);
      random_thresholds();
      idle_pct = idle;
      stall_pct <= stall;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i == PHASE_ITEMS / 2)
            random_thresholds();
         send_beat(random_pixel(), $urandom_range(0, 9) == 0);
      end
      drain();
   endtask

   initial begin
      foreach (color_count[i])
         color_count[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_thresholds();
      test_dominant_ties();
      test_threshold_extremes();
      test_backpressure();
      test_random_traffic(0, 0);
      test_random_traffic(50, 0);
      test_random_traffic(0, 50);
      test_random_traffic(13, 13);
      drain();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* sim.f */
src/hcv_pkg.sv
src/hcv_front.sv
src/hcv_queue.sv
src/hcv_back.sv
src/hsv_color_vote_classifier.sv
verif/tb_hsv_color_vote_classifier.sv
